### rtl/gdr_pkg.sv
// grid divergence with rms: shared types and constants
// field widths, opcodes, register indexes and the sequencer state type
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gdr_pkg;

  // configuration register widths and indexes
  localparam int DIM_W = 9;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;
  localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;
  localparam logic [DIM_W-1:0] DIM_MIN   = 9'd2;

  // input opcodes
  localparam logic OP_CELL  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // field widths
  localparam int FLOW_W = 16;
  localparam int DIV_W  = 27;
  localparam int IDX_W  = 8;
  localparam int RMS_W  = 26;
  localparam int SUM_W  = 64;
  localparam int MAG_W  = 27;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int AREA_W = 2 * DIM_W;
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 72;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_SQ,
    ST_ACC,
    ST_DIV,
    ST_SQRT,
    ST_OUT
  } gdr_state_t;

endpackage

`default_nettype wire

### rtl/grid_divergence_with_rms_top.sv
// Streaming forward-difference divergence of a 2D vector field, with a frame rms norm.
//
// Input beats on the s_ side carry one cell (flow_x, flow_y in signed Q8.8) with
// s_tuser = 0, or a drain tick with s_tuser = 1. Cells arrive in raster order; each
// cell from row 1 on gives the divergence of the cell straight above it, so results
// run one row late. After the last cell, one drain tick per column gives the bottom
// row. The last beat of the frame has m_tlast and m_tuser high and carries
// floor(sqrt(sum of squares / (width*height))), saturated to 26 bits.
// Cells during the drain and drain ticks outside it are dropped with no result.
// Sequence: a beat that gives a result passes the steps ST_MUL, ST_SUM, ST_SQ and
// ST_ACC before the output register loads in ST_OUT, and the next beat is taken once the
// sequencer is back in ST_IDLE; a top-row cell or a dropped beat leaves it idle. The final
// beat adds a bit-serial divide by width*height and then a square root.
// One beat is in flight at a time; the line buffer is read at acceptance and the
// difference, scaling, squaring and accumulation follow in a fixed step sequence.
// The output register holds a result while the receiver stalls, and the next input
// beat is still taken meanwhile. rst (synchronous) clears counters, the sum and the
// output valid and sets both dimensions to 256; the line buffer needs no clearing.
// Configuration writes are for idle periods only.
// depends on gdr_pkg
`timescale 1ns / 1ps
`default_nettype none

module grid_divergence_with_rms_top
  import gdr_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [DIM_W-1:0]      cfg_data,
  // input stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [S_DATA_W-1:0]   s_tdata,   // flow_x [15:0], flow_y [31:16]
  input  wire logic                  s_tuser,   // opcode
  // result stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [M_DATA_W-1:0]        m_tdata,   // div_value [26:0], row_index [34:27],
                                                // col_index [42:35], rms_norm [68:43]
  output logic                       m_tlast,   // frame_last
  output logic                       m_tuser    // rms_valid
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CCMP_W = ((CW > DIM_W) ? CW : DIM_W) + 1;
  localparam int RCMP_W = ((RW > DIM_W) ? RW : DIM_W) + 1;
  localparam int CX_W = (CW > IDX_W) ? CW : IDX_W;
  localparam int RX_W = (RW > IDX_W) ? RW : IDX_W;
  localparam int MEM_W = 2 * FLOW_W;
  localparam int DIF_W = FLOW_W + 1;
  localparam int REM_W = AREA_W + 1;
  localparam int SQ_REM_W = 34;
  localparam int ROOT_W = 32;

  // configuration registers
  logic [DIM_W-1:0] grid_width;
  logic [DIM_W-1:0] grid_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= DIM_RESET;
      grid_height <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped geometry
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;

  always_comb begin
    if (grid_width < DIM_MIN) w_eff = DIM_MIN;
    else if (32'(grid_width) > MAX_WIDTH) w_eff = DIM_W'(MAX_WIDTH);
    else w_eff = grid_width;
    if (grid_height < DIM_MIN) h_eff = DIM_MIN;
    else if (32'(grid_height) > MAX_HEIGHT) h_eff = DIM_W'(MAX_HEIGHT);
    else h_eff = grid_height;
  end

  // frame position and sum
  gdr_state_t      state;
  gdr_state_t      state_next;
  logic [CW-1:0]   col_count;
  logic [RW-1:0]   row_count;
  logic            drain_phase;
  logic [SUM_W-1:0] square_sum;

  // input beat decode
  logic                    in_beat;
  logic                    opcode;
  logic signed [FLOW_W-1:0] in_x;
  logic signed [FLOW_W-1:0] in_y;
  logic                    cell_ok;
  logic                    drain_ok;
  logic                    gives_result;
  logic                    row_end;
  logic                    frame_end;
  logic [CW-1:0]           addr_right;
  logic                    mem_we;

  assign in_beat  = s_tvalid & s_tready;
  assign opcode   = s_tuser;
  assign in_x     = s_tdata[FLOW_W-1:0];
  assign in_y     = s_tdata[2*FLOW_W-1:FLOW_W];
  assign cell_ok  = (opcode == OP_CELL) && !drain_phase;
  assign drain_ok = (opcode == OP_DRAIN) && drain_phase;
  assign gives_result = (cell_ok && (row_count != '0)) || drain_ok;
  assign row_end  = (CCMP_W'(col_count) + CCMP_W'(1)) >= CCMP_W'(w_eff);
  assign frame_end = (RCMP_W'(row_count) + RCMP_W'(1)) >= RCMP_W'(h_eff);
  assign addr_right = row_end ? col_count : col_count + CW'(1);
  assign mem_we   = in_beat && cell_ok;

  // line buffer: {y, x} per column, read at the cell and its right neighbour
  logic [MEM_W-1:0] line_mem [MAX_WIDTH];
  logic [MEM_W-1:0] rd_here;
  logic [MEM_W-1:0] rd_right;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[col_count] <= {in_y, in_x};
    end
    rd_here  <= line_mem[col_count];
    rd_right <= line_mem[addr_right];
  end

  // beat held for the step sequence
  logic                     hold_drain;
  logic                     hold_final;
  logic                     hold_row_end;
  logic signed [FLOW_W-1:0] hold_y;
  logic [RW-1:0]            hold_row;
  logic [CW-1:0]            hold_col;

  // datapath registers
  logic signed [DIV_W-1:0]  prod_x;
  logic signed [DIV_W-1:0]  prod_y;
  logic [AREA_W-1:0]        area;
  logic signed [DIV_W-1:0]  div_sat;
  logic [MAG_W-1:0]         div_mag;
  logic [SQ_W-1:0]          square;
  logic [SUM_W-1:0]         quot;
  logic [AREA_W-1:0]        div_rem;
  logic [SQ_REM_W-1:0]      sq_rem;
  logic [ROOT_W-1:0]        root;
  logic [5:0]               step;

  // difference and scaling operands
  logic signed [DIF_W-1:0]  x_here;
  logic signed [DIF_W-1:0]  x_right;
  logic signed [DIF_W-1:0]  y_here;
  logic signed [DIF_W-1:0]  y_below;
  logic signed [DIV_W-1:0]  dx_ext;
  logic signed [DIV_W-1:0]  dy_ext;
  logic signed [DIV_W-1:0]  w_ext;
  logic signed [DIV_W-1:0]  h_ext;

  always_comb begin
    x_here  = DIF_W'($signed(rd_here[FLOW_W-1:0]));
    y_here  = DIF_W'($signed(rd_here[MEM_W-1:FLOW_W]));
    x_right = hold_row_end ? '0 : DIF_W'($signed(rd_right[FLOW_W-1:0]));
    y_below = hold_drain ? '0 : DIF_W'(hold_y);
    dx_ext  = DIV_W'(x_right - x_here);
    dy_ext  = DIV_W'(y_below - y_here);
    w_ext   = DIV_W'($signed({1'b0, w_eff}));
    h_ext   = DIV_W'($signed({1'b0, h_eff}));
  end

  // sum, saturation and magnitude
  logic signed [DIV_W:0]    div_full;
  logic signed [DIV_W-1:0]  div_clip;

  always_comb begin
    div_full = {prod_x[DIV_W-1], prod_x} + {prod_y[DIV_W-1], prod_y};
    if (div_full[DIV_W] != div_full[DIV_W-1]) begin
      div_clip = div_full[DIV_W] ? {1'b1, {(DIV_W-1){1'b0}}} : {1'b0, {(DIV_W-1){1'b1}}};
    end else begin
      div_clip = div_full[DIV_W-1:0];
    end
  end

  // saturating accumulate
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_sat;

  always_comb begin
    sum_wide = {1'b0, square_sum} + (SUM_W+1)'(square);
    sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
  end

  // one restoring divide step
  logic [REM_W-1:0] rem_shift;
  logic             div_take;

  always_comb begin
    rem_shift = {div_rem, quot[SUM_W-1]};
    div_take  = rem_shift >= REM_W'(area);
  end

  // one square root step, two operand bits a step
  logic [SQ_REM_W+1:0] sq_shift;
  logic [SQ_REM_W+1:0] sq_trial;
  logic                sq_take;

  always_comb begin
    sq_shift = {sq_rem, quot[SUM_W-1:SUM_W-2]};
    sq_trial = (SQ_REM_W+2)'({root, 2'b01});
    sq_take  = sq_shift >= sq_trial;
  end

  // output slot
  logic out_free;
  logic out_load;
  assign out_free = !m_tvalid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_beat && gives_result) state_next = ST_MUL;
      ST_MUL:  state_next = ST_SUM;
      ST_SUM:  state_next = ST_SQ;
      ST_SQ:   state_next = ST_ACC;
      ST_ACC:  state_next = hold_final ? ST_DIV : ST_OUT;
      ST_DIV:  if (step == 6'd63) state_next = ST_SQRT;
      ST_SQRT: if (step[4:0] == 5'd31) state_next = ST_OUT;
      ST_OUT:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    s_tready = (state == ST_IDLE);
    out_load = (state == ST_OUT) && out_free;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      col_count   <= '0;
      row_count   <= '0;
      drain_phase <= 1'b0;
      square_sum  <= '0;
      step        <= '0;
    end else begin
      state <= state_next;
      // frame position moves on at acceptance
      if (in_beat && cell_ok) begin
        if (row_end) begin
          col_count <= '0;
          if (frame_end) drain_phase <= 1'b1;
          else row_count <= row_count + RW'(1);
        end else begin
          col_count <= col_count + CW'(1);
        end
      end else if (in_beat && drain_ok) begin
        if (row_end) begin
          col_count   <= '0;
          row_count   <= '0;
          drain_phase <= 1'b0;
        end else begin
          col_count <= col_count + CW'(1);
        end
      end
      // accumulate, the final beat hands the sum to the divider
      if (state == ST_ACC) begin
        square_sum <= hold_final ? '0 : sum_sat;
      end
      // shared step counter for divide and root
      if (state == ST_ACC) step <= '0;
      else if (state == ST_DIV || state == ST_SQRT) step <= (step == 6'd63) ? '0 : step + 6'd1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_beat) begin
      hold_drain   <= drain_ok;
      hold_final   <= drain_ok && row_end;
      hold_row_end <= row_end;
      hold_y       <= in_y;
      hold_row     <= cell_ok ? row_count - RW'(1) : row_count;
      hold_col     <= col_count;
    end
    unique case (state)
      ST_MUL: begin
        prod_x <= dx_ext * w_ext;
        prod_y <= dy_ext * h_ext;
        area   <= AREA_W'(w_eff) * AREA_W'(h_eff);
      end
      ST_SUM: begin
        div_sat <= div_clip;
        div_mag <= div_clip[DIV_W-1] ? MAG_W'(-div_clip) : MAG_W'(div_clip);
      end
      ST_SQ: begin
        square <= SQ_W'(div_mag) * SQ_W'(div_mag);
      end
      ST_ACC: begin
        quot    <= sum_sat;
        div_rem <= '0;
      end
      ST_DIV: begin
        quot    <= {quot[SUM_W-2:0], div_take};
        div_rem <= div_take ? AREA_W'(rem_shift - REM_W'(area)) : AREA_W'(rem_shift);
        // the root starts from the finished quotient
        sq_rem  <= '0;
        root    <= '0;
      end
      ST_SQRT: begin
        quot   <= {quot[SUM_W-3:0], 2'b00};
        sq_rem <= sq_take ? SQ_REM_W'(sq_shift - sq_trial) : SQ_REM_W'(sq_shift);
        root   <= {root[ROOT_W-2:0], sq_take};
      end
      default: ;
    endcase
  end

  // output register
  logic [RX_W-1:0]  row_wide;
  logic [CX_W-1:0]  col_wide;
  logic [RMS_W-1:0] rms_sat;

  always_comb begin
    row_wide = RX_W'(hold_row);
    col_wide = CX_W'(hold_col);
    if (root[ROOT_W-1:RMS_W] != '0) rms_sat = {RMS_W{1'b1}};
    else rms_sat = root[RMS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {3'b000,
                  hold_final ? rms_sat : {RMS_W{1'b0}},
                  col_wide[IDX_W-1:0],
                  row_wide[IDX_W-1:0],
                  div_sat};
      m_tlast <= hold_final;
      m_tuser <= hold_final;
    end
  end

endmodule

`default_nettype wire
